// File: rtl/cgks_pkg.sv
//------------------------------------------------------------------------------
// cgks_pkg
// Shared types and constants for the colour gradient keyframe sampler.
//------------------------------------------------------------------------------
`default_nettype none
package cgks_pkg;
  localparam int MaxKeys  = 16;
  localparam int TimeFrac = 16;
  localparam int ChanW    = 16;
  localparam int TimeW    = TimeFrac + 1;
  localparam int IdxW     = $clog2(MaxKeys);
  localparam int CntW     = $clog2(MaxKeys + 1);

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_SAMPLE = 2'd2;

  localparam logic [1:0] REG_RED   = 2'd0;
  localparam logic [1:0] REG_GREEN = 2'd1;
  localparam logic [1:0] REG_BLUE  = 2'd2;

  // controller -> datapath commands
  typedef struct packed {
    logic       load;      // capture input beat
    logic       clear;     // empty the table
    logic       scan;      // compare entry at scan index, advance
    logic       mark;      // latch insert position, jump to table end
    logic       shift;     // move entry idx-1 to idx, step down
    logic       place;     // write new key at idx, count up
    logic       fetch;     // read neighbour pair at idx-1, idx
    logic       div_step;  // one restoring divide step
    logic       mul;       // multiply stage
    logic       fin;       // build result
    logic [1:0] sel;       // result source code
    logic       drop;      // full-table status
  } cmd_t;

  localparam logic [1:0] SEL_ZERO = 2'd0;
  localparam logic [1:0] SEL_DEF  = 2'd1;
  localparam logic [1:0] SEL_KEY  = 2'd2;
  localparam logic [1:0] SEL_INT  = 2'd3;

  // datapath -> controller status
  typedef struct packed {
    logic [1:0] func;
    logic       full;
    logic       empty;
    logic       scan_end;   // scan index reached the count
    logic       scan_hit;   // current entry is later than the time (or, for a sample, equals entry 0)
    logic       shift_done; // idx equals insert position (sample: idx is 0)
    logic       div_done;
  } stat_t;
endpackage
`default_nettype wire

// File: rtl/cgks_ctrl.sv
//------------------------------------------------------------------------------
// cgks_ctrl
// Sequencer for clear, insert and sample operations.
//------------------------------------------------------------------------------
`default_nettype none
module cgks_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_fire,
  input  wire logic           out_busy,
  input  wire cgks_pkg::stat_t st,
  output logic                in_ready,
  output logic                res_load,
  output cgks_pkg::cmd_t      cmd
);
  import cgks_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_ISCAN = 4'd2;
  localparam logic [3:0] S_SHIFT = 4'd3;
  localparam logic [3:0] S_SSCAN = 4'd4;
  localparam logic [3:0] S_FETCH = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] state, state_next;
  logic [1:0] sel, sel_next;
  logic       drop, drop_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= SEL_ZERO;
      drop  <= 1'b0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      drop  <= drop_next;
    end
  end

  always_comb begin
    state_next = state;
    sel_next   = sel;
    drop_next  = drop;
    cmd        = '0;
    cmd.sel    = sel;
    cmd.drop   = drop;
    in_ready   = (state == S_IDLE);
    res_load   = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load   = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        sel_next   = SEL_ZERO;
        drop_next  = 1'b0;
        state_next = S_FIN;
        case (st.func)
          FUNC_CLEAR: cmd.clear = 1'b1;
          FUNC_INSERT: begin
            if (st.full) drop_next = 1'b1;
            else state_next = S_ISCAN;
          end
          FUNC_SAMPLE: begin
            if (st.empty) sel_next = SEL_DEF;
            else state_next = S_SSCAN;
          end
          default: ;
        endcase
      end
      // find the first entry later than the new time
      S_ISCAN: begin
        if (st.scan_end || st.scan_hit) begin
          cmd.mark   = 1'b1;
          state_next = S_SHIFT;
        end else cmd.scan = 1'b1;
      end
      S_SHIFT: begin
        if (st.shift_done) begin
          cmd.place  = 1'b1;
          state_next = S_FIN;
        end else cmd.shift = 1'b1;
      end
      // sample: find first entry later than t
      S_SSCAN: begin
        if (st.scan_end || st.scan_hit) state_next = S_FETCH;
        else cmd.scan = 1'b1;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        if (st.shift_done || st.scan_end) begin
          // at or before first key, or at or after last
          sel_next   = SEL_KEY;
          state_next = S_FIN;
        end else begin
          sel_next   = SEL_INT;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (st.div_done) state_next = S_MUL;
        else cmd.div_step = 1'b1;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_busy) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/cgks_dp.sv
//------------------------------------------------------------------------------
// cgks_dp
// Key table, scan pointer, serial divider, multipliers and result format.
//------------------------------------------------------------------------------
`default_nettype none
module cgks_dp (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire cgks_pkg::cmd_t             cmd,
  input  wire logic [1:0]                 in_func,
  input  wire logic signed [17:0]         in_key_time,
  input  wire logic [47:0]                in_key_col,
  input  wire logic [cgks_pkg::TimeW-1:0] in_sample_time,
  input  wire logic                       cfg_we,
  input  wire logic [1:0]                 cfg_idx,
  input  wire logic [15:0]                cfg_val,
  output cgks_pkg::stat_t                 st,
  output logic                            res_status,
  output logic [47:0]                     res_col,
  output logic [4:0]                      res_keys
);
  import cgks_pkg::*;

  localparam int DivW = TimeW + TimeFrac;

  logic [TimeW-1:0]   tstore [MaxKeys];
  logic [3*ChanW-1:0] cstore [MaxKeys];
  logic [CntW-1:0]    total;
  logic [CntW-1:0]    idx;
  logic [CntW-1:0]    ipos;
  logic [1:0]         func;
  logic [TimeW-1:0]   t;
  logic [3*ChanW-1:0] kcol;
  logic signed [ChanW-1:0] def_r, def_g, def_b;
  logic [IdxW-1:0]    ia, ib;
  logic [TimeW-1:0]   tl, tr;
  logic [3*ChanW-1:0] cl, cr;
  logic [DivW-1:0]    quo;
  logic [TimeW:0]     rem;
  logic [TimeW-1:0]   den;
  logic [5:0]         dcnt;
  logic               dbusy;
  logic signed [ChanW:0]          diff [3];
  logic signed [ChanW+TimeW+2:0]  prod [3];
  logic [3*ChanW-1:0] col;

  assign ia = idx[IdxW-1:0];
  assign ib = idx[IdxW-1:0] - 1'b1;

  // clamp key time to 0..1.0
  logic [TimeW-1:0] kt_clamp;
  always_comb begin
    if (in_key_time < 0) kt_clamp = '0;
    else if (in_key_time > 18'sd65536) kt_clamp = TimeW'(1 << TimeFrac);
    else kt_clamp = in_key_time[TimeW-1:0];
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      def_r <= 16'sd4096; def_g <= 16'sd4096; def_b <= 16'sd4096;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_RED:   def_r <= cfg_val;
        REG_GREEN: def_g <= cfg_val;
        REG_BLUE:  def_b <= cfg_val;
        default: ;
      endcase
    end
  end

  // key count
  always_ff @(posedge clk) begin
    if (rst) total <= '0;
    else if (cmd.clear) total <= '0;
    else if (cmd.place) total <= total + 1'b1;
  end

  // table memory and scan pointer; the shift phase walks idx from the
  // table end down to the insert position
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func <= in_func;
      t    <= (in_func == FUNC_INSERT) ? kt_clamp : in_sample_time;
      kcol <= in_key_col;
      idx  <= '0;
    end
    if (cmd.scan) idx <= idx + 1'b1;
    if (cmd.mark) begin
      ipos <= idx;
      idx  <= total;
    end
    if (cmd.shift) begin
      tstore[ia] <= tstore[ib];
      cstore[ia] <= cstore[ib];
      idx        <= idx - 1'b1;
    end
    if (cmd.place) begin
      tstore[ia] <= t;
      cstore[ia] <= kcol;
    end
    if (cmd.fetch) begin
      tl <= tstore[ib];
      tr <= tstore[ia];
      cl <= cstore[ib];
      cr <= (idx == total) ? cstore[ib] : cstore[ia];
      if (idx == '0) cl <= cstore[ia];
    end
  end

  // serial restoring divider: ((t - tl) << frac) / (tr - tl)
  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      dcnt  <= '0;
    end else if (cmd.fetch) begin
      dbusy <= 1'b1;
      dcnt  <= 6'(DivW);
    end else if (cmd.div_step) begin
      dcnt <= dcnt - 1'b1;
      if (dcnt == 6'd1) dbusy <= 1'b0;
    end
  end

  logic [TimeW:0] rem_sh;
  assign rem_sh = {rem[TimeW-1:0], quo[DivW-1]};
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      quo <= {t - tstore[ib], {TimeFrac{1'b0}}};
      rem <= '0;
      den <= tstore[ia] - tstore[ib];
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, den}) begin
        rem <= rem_sh - {1'b0, den};
        quo <= {quo[DivW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[DivW-2:0], 1'b0};
      end
    end
  end

  // interpolation multiply, one registered product per channel
  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_ch
      assign diff[g] = $signed({cr[g*ChanW+ChanW-1], cr[g*ChanW +: ChanW]})
                     - $signed({cl[g*ChanW+ChanW-1], cl[g*ChanW +: ChanW]});
      always_ff @(posedge clk) begin
        if (cmd.mul)
          prod[g] <= diff[g] * $signed({1'b0, quo[TimeW:0]})
                   + $signed((ChanW+TimeW+3)'(1 << (TimeFrac-1)));
      end
    end
  endgenerate

  // result selection and saturation
  always_comb begin
    logic signed [ChanW+TimeW+2:0] v;
    col = '0;
    for (int c = 0; c < 3; c++) begin
      v = (prod[c] >>> TimeFrac)
        + $signed({{(TimeW+3){cl[c*ChanW+ChanW-1]}}, cl[c*ChanW +: ChanW]});
      case (cmd.sel)
        SEL_DEF: col = {def_b, def_g, def_r};
        SEL_KEY: col[c*ChanW +: ChanW] = (idx == '0) ? cl[c*ChanW +: ChanW]
                                                      : cr[c*ChanW +: ChanW];
        SEL_INT: begin
          if (v > 32767) col[c*ChanW +: ChanW] = 16'h7fff;
          else if (v < -32768) col[c*ChanW +: ChanW] = 16'h8000;
          else col[c*ChanW +: ChanW] = v[ChanW-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      res_status <= cmd.drop;
      res_col    <= col;
      res_keys   <= 5'(total);
    end
  end

  // status to controller; a sample at exactly the first key's time stops
  // at entry 0 so that it takes the first key's colour
  assign st.func       = func;
  assign st.full       = (total == CntW'(MaxKeys));
  assign st.empty      = (total == '0);
  assign st.scan_end   = (idx == total);
  assign st.scan_hit   = (idx != total) && ((tstore[ia] > t) ||
                         (func == FUNC_SAMPLE && idx == '0 && tstore[ia] == t));
  assign st.shift_done = (func == FUNC_INSERT) ? (idx == ipos) : (idx == '0);
  assign st.div_done   = !dbusy;
endmodule
`default_nettype wire

// File: rtl/colour_gradient_keyframe_sampler_unit.sv
// Clear, dropped insert, empty sample and unused code go straight to the result;
// an insert scans the table and shifts the later keys up, and a sample scans the
// table and, to interpolate, runs the 33-step serial divider and the multipliers.
// One item is in work at a time; the next beat is taken once the result
// register has been loaded, so a stalled result adds its wait. Reset (rst,
// synchronous) empties the table and sets the default colour to 1.0.
//------------------------------------------------------------------------------
// colour_gradient_keyframe_sampler_unit
// Keyframe table with piecewise linear colour sampling.
//------------------------------------------------------------------------------
`default_nettype none
module colour_gradient_keyframe_sampler_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // tuser: func[1:0]
  input  wire logic [1:0]  s_tuser,
  // tdata: key_time[17:0], key_red, key_green, key_blue, sample_time[16:0], pad
  input  wire logic [87:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // tdata: status, out_red, out_green, out_blue, keys_held[4:0], pad
  output logic [55:0]      m_tdata,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [15:0] cfg_data
);
  import cgks_pkg::*;

  cmd_t  cmd;
  stat_t st;
  logic  res_load, res_status;
  logic [47:0] res_col;
  logic [4:0]  res_keys;

  cgks_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(s_tvalid && s_tready),
    .out_busy(m_tvalid && !m_tready), .st(st),
    .in_ready(s_tready), .res_load(res_load), .cmd(cmd)
  );

  cgks_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_func(s_tuser),
    .in_key_time(s_tdata[17:0]), .in_key_col(s_tdata[65:18]),
    .in_sample_time(s_tdata[82:66]),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_val(cfg_data),
    .st(st), .res_status(res_status), .res_col(res_col), .res_keys(res_keys)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (res_load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (res_load) m_tdata <= {2'b0, res_keys, res_col, res_status};
  end
endmodule
`default_nettype wire

// File: rtl/cgks_checker.sv
//------------------------------------------------------------------------------
// cgks_checker
// Port-level checks of the sampler.
//------------------------------------------------------------------------------
`default_nettype none
module cgks_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [55:0] m_tdata
);
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready) else $error("second beat taken");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata)) else $error("result moved");
  a_keys: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[53:49] <= 5'd16)) else $error("key count range");
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[55:54] == 2'b0)) else $error("pad bits set");
endmodule

bind colour_gradient_keyframe_sampler_unit cgks_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

// File: verif/colour_gradient_keyframe_sampler_unit_checker.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// colour_gradient_keyframe_sampler_unit_checker
// Watches the input, output and register ports of the keyframe sampler. It
// keeps its own keyframe table and default colour, works out the result beat
// for every accepted input beat, and compares each output beat field by field.
//------------------------------------------------------------------------------
`default_nettype none
module colour_gradient_keyframe_sampler_unit_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [1:0]  s_tuser,
  input  wire logic [87:0] s_tdata,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [55:0] m_tdata,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [15:0] cfg_data,
  output int               colours_owed,
  output int               mismatches
);
  import cgks_pkg::*;

  // laid out as on m_tdata, status in the lowest bit
  typedef struct packed {
    logic [4:0]  keys_held;
    logic [15:0] blue;
    logic [15:0] green;
    logic [15:0] red;
    logic        status;
  } colour_beat_t;

  // mirror of the keyframe table
  int unsigned key_times [MaxKeys];
  int          key_cols  [MaxKeys][3];
  int unsigned key_count;
  int          default_col [3];

  colour_beat_t owed_colours [$];

  assign colours_owed = owed_colours.size();

  function automatic int clip_channel(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  // apply one item to the mirrored table and build its result beat
  function automatic colour_beat_t gradient_step(logic [1:0] func, logic [87:0] d);
    colour_beat_t res;
    int          col [3];
    int          kt;
    int unsigned t, pos, r;
    longint      tl, tr, amount, diff, delta;
    res = '0;
    col = '{0, 0, 0};
    case (func)
      FUNC_CLEAR: begin
        key_count = 0;
      end
      FUNC_INSERT: begin
        if (key_count >= MaxKeys) begin
          res.status = 1'b1;
        end else begin
          kt = $signed(d[17:0]);
          if (kt < 0) kt = 0;
          if (kt > 65536) kt = 65536;
          t = kt;
          pos = 0;
          while (pos < key_count && key_times[pos] <= t) pos++;
          for (int i = key_count; i > pos; i--) begin
            key_times[i] = key_times[i-1];
            key_cols[i]  = key_cols[i-1];
          end
          key_times[pos]   = t;
          key_cols[pos][0] = $signed(d[33:18]);
          key_cols[pos][1] = $signed(d[49:34]);
          key_cols[pos][2] = $signed(d[65:50]);
          key_count++;
        end
      end
      FUNC_SAMPLE: begin
        t = d[82:66];
        if (key_count == 0) begin
          col = default_col;
        end else if (t <= key_times[0]) begin
          col = key_cols[0];
        end else if (t >= key_times[key_count-1]) begin
          col = key_cols[key_count-1];
        end else begin
          r = 1;
          while (r < key_count - 1 && key_times[r] <= t) r++;
          tl = key_times[r-1];
          tr = key_times[r];
          amount = (tr > tl) ? (((longint'(t) - tl) <<< 16) / (tr - tl)) : 65536;
          for (int c = 0; c < 3; c++) begin
            diff   = longint'(key_cols[r][c]) - key_cols[r-1][c];
            delta  = diff * amount + 32768;
            col[c] = clip_channel(key_cols[r-1][c] + (delta >>> 16));
          end
        end
      end
      default: ;  // unused code: no effect
    endcase
    res.red       = col[0][15:0];
    res.green     = col[1][15:0];
    res.blue      = col[2][15:0];
    res.keys_held = key_count[4:0];
    return res;
  endfunction

  always @(posedge clk) begin
    colour_beat_t got, want;
    if (rst) begin
      key_count   = 0;
      default_col = '{4096, 4096, 4096};
      owed_colours.delete();
      mismatches  = 0;
    end else begin
      if (cfg_we && cfg_idx <= REG_BLUE) default_col[cfg_idx] = $signed(cfg_data);
      if (s_tvalid && s_tready)
        owed_colours = {owed_colours, gradient_step(s_tuser, s_tdata)};
      if (m_tvalid && m_tready) begin
        got = m_tdata[53:0];
        if (owed_colours.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: unexpected result beat %h", $realtime, got);
        end else begin
          want = owed_colours.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch st %0d/%0d rgb %h %h %h / %h %h %h keys %0d/%0d",
                       $realtime, want.status, got.status, want.red, want.green,
                       want.blue, got.red, got.green, got.blue, want.keys_held,
                       got.keys_held);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: verif/colour_gradient_keyframe_sampler_unit_tb.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// colour_gradient_keyframe_sampler_unit_tb
// Drives clear, insert, sample and unused-code beats into the keyframe sampler
// with random gaps and output stalls, rewrites the default colour between
// phases, and takes the verdict from the checker beside the block.
//------------------------------------------------------------------------------
`default_nettype none
module colour_gradient_keyframe_sampler_unit_tb;
  import cgks_pkg::*;

  localparam int StallLimit = 5000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [1:0]  s_tuser = '0;
  logic [87:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [15:0] cfg_data = '0;

  int colours_owed, mismatches;
  int beats_sent;
  int quiet_idle_cnt;
  bit long_hold, no_idle;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  colour_gradient_keyframe_sampler_unit dut (.*);

  colour_gradient_keyframe_sampler_unit_checker u_checker (.*);

  // one beat on the input channel, after a random gap
  task automatic send_item(logic [1:0] func, logic [17:0] kt, logic [15:0] r,
                           logic [15:0] g, logic [15:0] b, logic [16:0] st);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {5'b0, st, b, g, r, kt};
    do @(posedge clk); while (!s_tready);
    beats_sent++;
  endtask

  task automatic insert_key(logic [17:0] kt);
    send_item(FUNC_INSERT, kt, $urandom(), $urandom(), $urandom(), $urandom());
  endtask

  task automatic sample_at(logic [16:0] st);
    send_item(FUNC_SAMPLE, $urandom(), $urandom(), $urandom(), $urandom(), st);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // drain the block, then load a new default colour
  task automatic set_defaults(logic [15:0] r, logic [15:0] g, logic [15:0] b);
    s_tvalid <= 1'b0;
    wait (colours_owed == 0);
    repeat (80) @(posedge clk);
    write_reg(REG_RED, r);
    write_reg(REG_GREEN, g);
    write_reg(REG_BLUE, b);
    write_reg(2'd3, $urandom());  // unmapped index, ignored
  endtask

  // result side: random ready delay per beat, plus long hold-offs on request
  initial begin
    int w;
    @(posedge clk iff !rst);
    forever begin
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end
      w = no_idle ? 0 : $urandom_range(0, 3);
      if (w != 0) begin
        m_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_idle_cnt <= 0;
    end else if (quiet_idle_cnt >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_idle_cnt <= quiet_idle_cnt + 1;
    end
  end

  initial begin
    int          nkeys;
    logic [17:0] kt, last_t;
    beats_sent = 0;
    long_hold  = 1'b0;
    no_idle    = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_reg(REG_RED, 16'h7fff);
    write_reg(REG_GREEN, 16'h8000);
    write_reg(REG_BLUE, 16'h1234);

    // directed: empty table, time extremes, unused code, full table
    sample_at(17'd0);
    send_item(FUNC_CLEAR, 0, 0, 0, 0, 0);
    send_item(FUNC_INSERT, 18'h20000, 16'h7fff, 16'h8000, 16'h7fff, 17'h1ffff);
    send_item(FUNC_INSERT, 18'h1ffff, 16'h8000, 16'h7fff, 16'h0000, 17'h1ffff);
    sample_at(17'd0);
    sample_at(17'd32768);
    sample_at(17'd65536);
    sample_at(17'h1ffff);
    send_item(2'd3, 18'h3ffff, 16'hffff, 16'hffff, 16'hffff, 17'h1ffff);
    for (int i = 0; i < 14; i++) insert_key($urandom_range(0, 65536));
    insert_key(18'd100);
    sample_at($urandom_range(1, 65535));
    send_item(FUNC_CLEAR, 0, 0, 0, 0, 0);
    set_defaults(16'h8000, 16'h7fff, 16'h0000);
    sample_at(17'd5);

    // random: mostly clear, fill, then sample; some noise beats
    while (beats_sent < 1050) begin
      if (beats_sent > 350 && beats_sent < 380) set_defaults($urandom(), $urandom(), $urandom());
      if (beats_sent > 700 && beats_sent < 730) set_defaults(16'h7fff, 16'h7fff, 16'h8000);
      if (beats_sent > 500 && beats_sent < 530) begin
        s_tvalid <= 1'b0;
        wait (colours_owed == 0);
        long_hold = 1'b1;
      end
      no_idle = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) < 8) begin
        send_item(FUNC_CLEAR, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        nkeys  = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 8);
        last_t = $urandom_range(0, 65536);
        for (int i = 0; i < nkeys; i++) begin
          case ($urandom_range(0, 4))
            0: kt = $urandom();
            1: kt = last_t;
            default: kt = $urandom_range(0, 65536);
          endcase
          last_t = kt;
          insert_key(kt);
        end
        repeat ($urandom_range(2, 8))
          sample_at(($urandom_range(0, 7) == 0) ? 17'($urandom()) : 17'($urandom_range(0, 65536)));
      end else begin
        send_item($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      end
    end
    s_tvalid <= 1'b0;
    no_idle = 1'b0;

    wait (colours_owed == 0);
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
